/* rtl/core/cce_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cce_pkg
// Shared types and constants of the cycle counter extension block.
// ----------------------------------------------------------------------------
package cce_pkg;

  localparam logic [1:0] OP_RAW = 2'd0;
  localparam logic [1:0] OP_US  = 2'd1;
  localparam logic [1:0] OP_NS  = 2'd2;

  localparam logic [31:0] US_PER_SEC = 32'd1000000;
  localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
  localparam logic [63:0] NS_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [2:0] REG_CORE_CLOCK_HZ = 3'd0;

  typedef struct packed {
    logic [31:0] rem;
    logic        qbit;
  } step_t;

endpackage

/* rtl/core/cycle_counter_extend_to_time_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cycle_counter_extend_to_time_top
// Extends 32-bit cycle counter samples to 64 bits and converts to time.
// ----------------------------------------------------------------------------
// Each input beat carries a counter sample and a request kind. The block keeps
// a wrap count, forms the 64-bit cycle count and returns it raw or converted
// to microseconds or nanoseconds using the core clock register. The block
// handles one beat at a time. Raw requests, unused request kinds and requests
// made while the clock register is zero go straight from the idle state to the
// result stage. A time conversion runs a 64-step division of the cycle count
// by the clock, three 32x32 multiply steps on one shared multiplier and one
// setup step, a 32-step division of the scaled remainder, a final add and
// clamp, and then the result stage, which loads the result register. Both
// divisions use the single restoring division step unit. A result that has
// not been taken holds the block in its result stage, and the input stays
// stalled until the result register is free.
// ----------------------------------------------------------------------------
module cycle_counter_extend_to_time_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_counter_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_time_value,
  output logic        out_saturated
);

  logic [31:0] core_clock_hz;

  cce_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .core_clock_hz (core_clock_hz)
  );

  cce_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .core_clock_hz     (core_clock_hz),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_counter_sample (in_counter_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_time_value    (out_time_value),
    .out_saturated     (out_saturated)
  );

endmodule

/* rtl/core/cce_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cce_regs
// APB-style configuration register holding the core clock frequency.
// ----------------------------------------------------------------------------
module cce_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] core_clock_hz
);

  logic [31:0] clk_hz_r;
  logic [31:0] clk_hz_nxt;
  logic        sel_clk;

  assign sel_clk = (paddr[2] == cce_pkg::REG_CORE_CLOCK_HZ[2]);
  assign pready  = 1'b1;
  assign prdata  = sel_clk ? clk_hz_r : 32'd0;
  assign core_clock_hz = clk_hz_r;

  always_comb begin
    clk_hz_nxt = clk_hz_r;
    if (psel && penable && pwrite && sel_clk) begin
      clk_hz_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= 32'd0;
    end else begin
      clk_hz_r <= clk_hz_nxt;
    end
  end

endmodule

/* rtl/core/cce_div_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cce_div_step
// One restoring division step: shift in a dividend bit, compare, subtract.
// ----------------------------------------------------------------------------
module cce_div_step (
  input  logic [31:0]        rem_i,
  input  logic               bit_i,
  input  logic [31:0]        divisor_i,
  output cce_pkg::step_t     step_o
);

  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem_i, bit_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    if (trial >= {1'b0, divisor_i}) begin
      step_o.rem  = diff[31:0];
      step_o.qbit = 1'b1;
    end else begin
      step_o.rem  = trial[31:0];
      step_o.qbit = 1'b0;
    end
  end

endmodule

/* rtl/core/cce_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cce_seq
// Sequencer: counter extension, serial division and multiply steps.
// ----------------------------------------------------------------------------
module cce_seq (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] core_clock_hz,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_counter_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_time_value,
  output logic        out_saturated
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV1 = 4'd1;
  localparam logic [3:0] ST_MUL0 = 4'd2;
  localparam logic [3:0] ST_MUL1 = 4'd3;
  localparam logic [3:0] ST_MUL2 = 4'd4;
  localparam logic [3:0] ST_MUL3 = 4'd5;
  localparam logic [3:0] ST_DIV2 = 4'd6;
  localparam logic [3:0] ST_ADD  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic        started_r, started_nxt;
  logic [31:0] last_r, last_nxt;
  logic [31:0] wrap_r, wrap_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [31:0] units_r, units_nxt;
  logic [63:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] whole_r, whole_nxt;
  logic        ovf_r, ovf_nxt;
  logic [63:0] res_r, res_nxt;
  logic        sat_r, sat_nxt;
  logic [63:0] out_val_r, out_val_nxt;
  logic        out_sat_r, out_sat_nxt;

  logic [31:0]    base;
  logic [31:0]    wrap_base;
  logic [31:0]    wrap_ext;
  logic [31:0]    mul_a;
  logic [63:0]    prod_full;
  logic [32:0]    hsum;
  logic [64:0]    sum;
  cce_pkg::step_t step;

  cce_div_step u_step (
    .rem_i     (rem_r),
    .bit_i     (q_r[63]),
    .divisor_i (core_clock_hz),
    .step_o    (step)
  );

  assign base      = started_r ? last_r : in_counter_sample;
  assign wrap_base = started_r ? wrap_r : 32'd0;
  assign wrap_ext  = wrap_base + {31'd0, (in_counter_sample < base)};

  always_comb begin
    case (state_r)
      ST_MUL1: mul_a = q_r[63:32];
      ST_MUL2: mul_a = rem_r;
      default: mul_a = q_r[31:0];
    endcase
  end

  assign prod_full = {32'd0, mul_a} * {32'd0, units_r};
  assign hsum      = {1'b0, prod_r[31:0]} + {1'b0, whole_r[63:32]};
  assign sum       = {1'b0, whole_r} + {33'd0, q_r[31:0]};

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_time_value = out_val_r;
  assign out_saturated  = out_sat_r;

  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    last_nxt      = last_r;
    wrap_nxt      = wrap_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    units_nxt     = units_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    whole_nxt     = whole_r;
    ovf_nxt       = ovf_r;
    res_nxt       = res_r;
    sat_nxt       = sat_r;
    out_val_nxt   = out_val_r;
    out_sat_nxt   = out_sat_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          started_nxt = 1'b1;
          last_nxt    = in_counter_sample;
          wrap_nxt    = wrap_ext;
          op_nxt      = in_op;
          units_nxt   = (in_op == cce_pkg::OP_NS) ? cce_pkg::NS_PER_SEC
                                                  : cce_pkg::US_PER_SEC;
          sat_nxt     = 1'b0;
          if (in_op == cce_pkg::OP_RAW) begin
            res_nxt   = {wrap_ext, in_counter_sample};
            state_nxt = ST_FIN;
          end else if ((in_op != cce_pkg::OP_US && in_op != cce_pkg::OP_NS) ||
                       core_clock_hz == 32'd0) begin
            res_nxt   = 64'd0;
            state_nxt = ST_FIN;
          end else begin
            q_nxt     = {wrap_ext, in_counter_sample};
            rem_nxt   = 32'd0;
            cnt_nxt   = 6'd63;
            state_nxt = ST_DIV1;
          end
        end
      end
      ST_DIV1, ST_DIV2: begin
        rem_nxt = step.rem;
        q_nxt   = {q_r[62:0], step.qbit};
        if (cnt_r == 6'd0) begin
          state_nxt = (state_r == ST_DIV1) ? ST_MUL0 : ST_ADD;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      ST_MUL0: begin
        prod_nxt  = prod_full;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        whole_nxt = prod_r;
        prod_nxt  = prod_full;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        ovf_nxt           = (prod_r[63:32] != 32'd0) || hsum[32];
        whole_nxt[63:32]  = hsum[31:0];
        prod_nxt          = prod_full;
        state_nxt         = ST_MUL3;
      end
      ST_MUL3: begin
        rem_nxt   = prod_r[63:32];
        q_nxt     = {prod_r[31:0], 32'd0};
        cnt_nxt   = 6'd31;
        state_nxt = ST_DIV2;
      end
      ST_ADD: begin
        if (ovf_r || sum[64]) begin
          res_nxt = (op_r == cce_pkg::OP_NS) ? cce_pkg::NS_MAX : '1;
          sat_nxt = 1'b1;
        end else if (op_r == cce_pkg::OP_NS && sum[63]) begin
          res_nxt = cce_pkg::NS_MAX;
          sat_nxt = 1'b1;
        end else begin
          res_nxt = sum[63:0];
          sat_nxt = 1'b0;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_r;
          out_sat_nxt   = sat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      last_r      <= 32'd0;
      wrap_r      <= 32'd0;
      out_valid_r <= 1'b0;
      cnt_r       <= 6'd0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      last_r      <= last_nxt;
      wrap_r      <= wrap_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    units_r   <= units_nxt;
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    prod_r    <= prod_nxt;
    whole_r   <= whole_nxt;
    ovf_r     <= ovf_nxt;
    res_r     <= res_nxt;
    sat_r     <= sat_nxt;
    out_val_r <= out_val_nxt;
    out_sat_r <= out_sat_nxt;
  end

  // A raw-cycle beat needs no arithmetic and goes straight to the result stage.
  a_raw_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == cce_pkg::OP_RAW) |=> (state_r == ST_FIN))
    else $error("raw beat did not go straight to the result stage");

  // The partial remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV1 || state_r == ST_DIV2) |-> (rem_r < core_clock_hz))
    else $error("division remainder not below the divisor");

  // A clamped result holds one of the two saturation values.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      (out_val_r == cce_pkg::NS_MAX || out_val_r == 64'hFFFF_FFFF_FFFF_FFFF))
    else $error("saturated result with an unexpected value");

  // A new result appears only when leaving the result stage.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN && state_r == ST_IDLE))
    else $error("result raised outside the result stage");

endmodule

/* tb/tb_cycle_counter_extend_to_time_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cycle_counter_extend_to_time_top
// Self-checking testbench for the cycle counter extension block.
// ----------------------------------------------------------------------------
// A short table of directed beats covers the first reading, wraps, every
// request kind, the zero clock and the saturation cases. Random phases follow,
// each with its own core clock written over the register port and read back,
// using counter-like sample streams with some noise. A burst of falling
// samples then wraps the counter on almost every beat. Every result is
// compared with its table value or a predictor kept inside the bench, while
// both sides insert random gaps and the receiver once holds off long.
// ----------------------------------------------------------------------------
module tb_cycle_counter_extend_to_time_top;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [2:0] CLOCK_ADDR = 3'(cce_pkg::REG_CORE_CLOCK_HZ * 4);
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned WRAP_BURST = 50;
  localparam int NUM_ROWS = 18;

  typedef struct packed {
    logic [63:0] time_value;
    logic        saturated;
  } time_result_t;

  typedef struct packed {
    logic [31:0] hz;
    logic [1:0]  op;
    logic [31:0] sample;
    logic        typed;
    logic [63:0] time_value;
    logic        saturated;
  } beat_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = cce_pkg::OP_RAW;
  logic [31:0] in_counter_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_time_value;
  logic        out_saturated;

  time_result_t pending_times [$];
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  bit           no_idle = 1'b0;
  bit           hold_req = 1'b0;

  logic [31:0] core_hz = '0;
  logic [31:0] prev_sample = '0;
  logic [31:0] wrap_count_q = '0;
  logic        seen_any = 1'b0;
  logic [31:0] counter_now = '0;

  beat_row_t directed_rows [NUM_ROWS] = '{
    '{32'd0, cce_pkg::OP_RAW, 32'h0000_1000, 1'b1, 64'h0000_0000_0000_1000, 1'b0},
    '{32'd0, cce_pkg::OP_RAW, 32'h0000_0800, 1'b1, 64'h0000_0001_0000_0800, 1'b0},
    '{32'd0, cce_pkg::OP_US, 32'h0000_0900, 1'b1, 64'd0, 1'b0},
    '{32'd0, cce_pkg::OP_NS, 32'hFFFF_FFFF, 1'b1, 64'd0, 1'b0},
    '{32'd0, OP_NONE, 32'h0000_0000, 1'b1, 64'd0, 1'b0},
    '{32'd0, cce_pkg::OP_RAW, 32'hFFFF_FFFF, 1'b1, 64'h0000_0002_FFFF_FFFF, 1'b0},
    '{32'd1, cce_pkg::OP_NS, 32'h0000_0000, 1'b1, cce_pkg::NS_MAX, 1'b1},
    '{32'd1, cce_pkg::OP_US, 32'h0000_0001, 1'b0, 64'd0, 1'b0},
    '{32'd1, OP_NONE, 32'h0000_0000, 1'b1, 64'd0, 1'b0},
    '{32'd1, cce_pkg::OP_RAW, 32'h0000_0007, 1'b1, 64'h0000_0004_0000_0007, 1'b0},
    '{32'hFFFF_FFFF, cce_pkg::OP_US, 32'hFFFF_FFFF, 1'b0, 64'd0, 1'b0},
    '{32'hFFFF_FFFF, cce_pkg::OP_NS, 32'h0000_0000, 1'b0, 64'd0, 1'b0},
    '{32'hFFFF_FFFF, cce_pkg::OP_RAW, 32'h8000_0000, 1'b1, 64'h0000_0005_8000_0000, 1'b0},
    '{32'd100000000, cce_pkg::OP_US, 32'h8000_0001, 1'b0, 64'd0, 1'b0},
    '{32'd100000000, cce_pkg::OP_NS, 32'hC000_0000, 1'b0, 64'd0, 1'b0},
    '{32'd100000000, cce_pkg::OP_NS, 32'h4000_0000, 1'b0, 64'd0, 1'b0},
    '{32'd100000000, cce_pkg::OP_US, 32'h4000_0000, 1'b0, 64'd0, 1'b0},
    '{32'd100000000, cce_pkg::OP_RAW, 32'h4000_0000, 1'b1, 64'h0000_0006_4000_0000, 1'b0}
  };

  cycle_counter_extend_to_time_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_counter_sample (in_counter_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_time_value    (out_time_value),
    .out_saturated     (out_saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] cycles_to_units(input logic [63:0] cycles,
                                                  input logic [63:0] per_sec,
                                                  output logic clamped);
    logic [63:0] hz64;
    logic [63:0] secs;
    logic [63:0] rem;
    logic [63:0] whole;
    logic [63:0] frac;
    clamped = 1'b0;
    hz64 = {32'd0, core_hz};
    if (hz64 == 64'd0) return 64'd0;
    secs = cycles / hz64;
    rem = cycles % hz64;
    if (secs > ({64{1'b1}} / per_sec)) begin
      clamped = 1'b1;
      return {64{1'b1}};
    end
    whole = secs * per_sec;
    frac = (rem * per_sec) / hz64;
    if (whole > ({64{1'b1}} - frac)) begin
      clamped = 1'b1;
      return {64{1'b1}};
    end
    return whole + frac;
  endfunction

  function automatic time_result_t predict_time(input logic [1:0] op,
                                                input logic [31:0] sample);
    time_result_t r;
    logic [63:0]  cycles;
    logic         clamped;
    if (!seen_any) begin
      prev_sample = sample;
      wrap_count_q = '0;
      seen_any = 1'b1;
    end
    if (sample < prev_sample) wrap_count_q = wrap_count_q + 32'd1;
    prev_sample = sample;
    cycles = {wrap_count_q, sample};
    r.time_value = 64'd0;
    r.saturated = 1'b0;
    case (op)
      cce_pkg::OP_RAW: begin
        r.time_value = cycles;
      end
      cce_pkg::OP_US: begin
        r.time_value = cycles_to_units(cycles, {32'd0, cce_pkg::US_PER_SEC}, clamped);
        r.saturated = clamped;
      end
      cce_pkg::OP_NS: begin
        r.time_value = cycles_to_units(cycles, {32'd0, cce_pkg::NS_PER_SEC}, clamped);
        r.saturated = clamped;
        if (r.time_value > cce_pkg::NS_MAX) begin
          r.time_value = cce_pkg::NS_MAX;
          r.saturated = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] next_reading();
    logic [31:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: counter_now = counter_now + $urandom_range(0, 4096);
      4, 5: counter_now = counter_now + $urandom_range(0, 32'h00FF_FFFF);
      6: counter_now = counter_now + $urandom();
      7: counter_now = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: begin
      end
    endcase
    s = counter_now;
    if ($urandom_range(0, 9) == 0) s = $urandom();
    return s;
  endfunction

  function automatic logic [1:0] next_op();
    if ($urandom_range(0, 15) == 0) return OP_NONE;
    return 2'($urandom_range(0, 2));
  endfunction

  function automatic logic [31:0] pick_clock();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom();
      4: return $urandom_range(2, 1000);
      default: return $urandom_range(1000000, 32'hEE6B_2800);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch at %0t: %s expected %h got %h", $realtime, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    time_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_times.size() == 0) begin
        report_mismatch("unexpected result beat, time_value", 64'd0, out_time_value);
      end else begin
        want = pending_times.pop_front();
        if (out_time_value !== want.time_value)
          report_mismatch("time_value", want.time_value, out_time_value);
        if (out_saturated !== want.saturated)
          report_mismatch("saturated", 64'(want.saturated), 64'(out_saturated));
      end
    end
  end

  initial begin : receiver
    int unsigned stall;
    forever begin
      if (hold_req) stall = HOLD_CYCLES;
      else stall = no_idle ? 0 : $urandom_range(0, 14);
      hold_req = 1'b0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_reading(input logic [1:0] op, input logic [31:0] sample,
                              input logic typed, input time_result_t typed_result);
    int unsigned  gap;
    time_result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_counter_sample <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_time(op, sample);
    pending_times.push_back(typed ? typed_result : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_times.size() != 0);
  endtask

  task automatic write_clock(input logic [31:0] hz);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CLOCK_ADDR;
    cfg_pwdata <= hz;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    core_hz = hz;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== hz) report_mismatch("core_clock_hz readback", 64'(hz), 64'(cfg_prdata));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] hz, input int unsigned beats);
    wait_drained();
    write_clock(hz);
    for (int unsigned i = 0; i < beats; i++)
      send_reading(next_op(), next_reading(), 1'b0, '0);
  endtask

  initial begin : stimulus
    time_result_t typed_result;
    logic [31:0]  falling;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (directed_rows[i].hz != core_hz) begin
        wait_drained();
        write_clock(directed_rows[i].hz);
      end
      typed_result.time_value = directed_rows[i].time_value;
      typed_result.saturated = directed_rows[i].saturated;
      send_reading(directed_rows[i].op, directed_rows[i].sample,
                   directed_rows[i].typed, typed_result);
    end

    for (int k = 0; k < 15; k++) begin
      no_idle = (k % 4 == 3);
      if (k == 5) hold_req = 1'b1;
      case (k)
        0: run_phase(32'd0, 20);
        1: run_phase(32'd1, 20);
        2: run_phase(32'hFFFF_FFFF, 20);
        default: run_phase(pick_clock(), 20);
      endcase
    end

    // Falling samples wrap on almost every beat, so that later nanosecond
    // results at a one hertz clock saturate.
    wait_drained();
    write_clock(32'd1);
    no_idle = 1'b1;
    falling = 32'hFFFF_FFFF;
    for (int unsigned i = 0; i < WRAP_BURST; i++) begin
      if (falling < 32'h0010_0000) falling = 32'hFFFF_FFFF;
      else falling = falling - $urandom_range(1, 32'h000F_FFFF);
      send_reading(cce_pkg::OP_RAW, falling, 1'b0, '0);
    end
    counter_now = falling;
    no_idle = 1'b0;

    run_phase(32'd1, 20);
    run_phase(32'd2, 20);
    run_phase(32'd3, 20);
    run_phase(pick_clock(), 20);

    wait_drained();
    repeat (120) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
